[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the write drain unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DRSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle outside reset.
`define DRSW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/drsw_pkg.sv]
// Package of the DRAM write drain scheduler: sizes, command and register
// codes, and the structs passed between the top level, config and cells.
`default_nettype none

package drsw_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TIME_BITS   = 32;

  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W = TIME_BITS;
  localparam int AGE_W  = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [2:0] CMD_INS_RD   = 3'd0;
  localparam logic [2:0] CMD_INS_WR   = 3'd1;
  localparam logic [2:0] CMD_REMOVE   = 3'd2;
  localparam logic [2:0] CMD_SET_RDY  = 3'd3;
  localparam logic [2:0] CMD_SCHEDULE = 3'd4;

  localparam logic [1:0] REG_HIGH_WM = 2'd0;
  localparam logic [1:0] REG_LOW_WM  = 2'd1;
  localparam logic [1:0] REG_AGE_THR = 2'd2;

  localparam logic [6:0]  HIGH_WM_RST = 7'd40;
  localparam logic [6:0]  LOW_WM_RST  = 7'd20;
  localparam logic [15:0] AGE_THR_RST = 16'd50;

  typedef struct packed {
    logic [6:0]  high_wm;
    logic [6:0]  low_wm;
    logic [15:0] age_thr;
  } cfg_t;

  typedef struct packed {
    logic              ins_rd;
    logic              ins_wr;
    logic              rm_rd;
    logic              rm_wr;
    logic              set_rd;
    logic              set_wr;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] arrival;
    logic              rdy;
  } upd_t;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] age;
  } cand_t;

  typedef struct packed {
    cand_t wr;
    cand_t old_rd;
    cand_t yng_rd;
  } chain_t;

endpackage

`default_nettype wire

[hw/rtl/drsw_cfg.sv]
// APB-style register file for the watermarks and the age threshold.
// Depends on drsw_pkg.
`default_nettype none

module drsw_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output drsw_pkg::cfg_t    cfg
);

  logic [6:0]  high_wm_r;
  logic [6:0]  low_wm_r;
  logic [15:0] age_thr_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_wm_r <= drsw_pkg::HIGH_WM_RST;
      low_wm_r  <= drsw_pkg::LOW_WM_RST;
      age_thr_r <= drsw_pkg::AGE_THR_RST;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        drsw_pkg::REG_HIGH_WM: high_wm_r <= cfg_pwdata[6:0];
        drsw_pkg::REG_LOW_WM:  low_wm_r  <= cfg_pwdata[6:0];
        drsw_pkg::REG_AGE_THR: age_thr_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      drsw_pkg::REG_HIGH_WM: cfg_prdata = {25'd0, high_wm_r};
      drsw_pkg::REG_LOW_WM:  cfg_prdata = {25'd0, low_wm_r};
      drsw_pkg::REG_AGE_THR: cfg_prdata = {16'd0, age_thr_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.high_wm = high_wm_r;
  assign cfg.low_wm  = low_wm_r;
  assign cfg.age_thr = age_thr_r;

endmodule

`default_nettype wire

[hw/rtl/drsw_cell.sv]
// One slot of the scheduler: a read entry and a write entry, and one stage
// of the oldest-first search chain. Depends on drsw_pkg.
`default_nettype none

module drsw_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [drsw_pkg::SLOT_W-1:0]   cell_idx,
  input  drsw_pkg::upd_t                     upd,
  input  wire logic [drsw_pkg::TIME_W-1:0]   now,
  input  wire logic [15:0]                   age_thr,
  input  drsw_pkg::chain_t                   chain_in,
  output drsw_pkg::chain_t                   chain_out,
  output logic                               rd_valid,
  output logic                               wr_valid
);

  logic                          rd_vld_r;
  logic                          rd_rdy_r;
  logic [drsw_pkg::TIME_W-1:0]   rd_arr_r;
  logic                          wr_vld_r;
  logic                          wr_rdy_r;
  logic [drsw_pkg::TIME_W-1:0]   wr_arr_r;
  drsw_pkg::chain_t              chain_r;
  drsw_pkg::chain_t              chain_nxt;

  logic                          hit;
  logic                          rd_own;
  logic                          wr_own;
  logic                          rd_old;
  logic [drsw_pkg::TIME_W-1:0]   rd_age;
  logic [drsw_pkg::TIME_W-1:0]   wr_age;

  assign hit = (upd.slot == cell_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_rdy_r <= 1'b0;
      wr_vld_r <= 1'b0;
      wr_rdy_r <= 1'b0;
    end else if (hit) begin
      if (upd.ins_rd) begin
        rd_vld_r <= 1'b1;
        rd_rdy_r <= upd.rdy;
      end else if (upd.rm_rd) begin
        rd_vld_r <= 1'b0;
        rd_rdy_r <= 1'b0;
      end else if (upd.set_rd && rd_vld_r) begin
        rd_rdy_r <= upd.rdy;
      end
      if (upd.ins_wr) begin
        wr_vld_r <= 1'b1;
        wr_rdy_r <= upd.rdy;
      end else if (upd.rm_wr) begin
        wr_vld_r <= 1'b0;
        wr_rdy_r <= 1'b0;
      end else if (upd.set_wr && wr_vld_r) begin
        wr_rdy_r <= upd.rdy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && upd.ins_rd) rd_arr_r <= upd.arrival;
    if (hit && upd.ins_wr) wr_arr_r <= upd.arrival;
  end

  // Merge the own entries into the best-so-far from lower slots; strict
  // compare keeps the lower slot on equal age.
  always_comb begin
    rd_own    = rd_vld_r && rd_rdy_r;
    wr_own    = wr_vld_r && wr_rdy_r;
    rd_age    = now - rd_arr_r;
    wr_age    = now - wr_arr_r;
    rd_old    = (drsw_pkg::AGE_W'(rd_age) >= drsw_pkg::AGE_W'(age_thr));
    chain_nxt = chain_in;
    if (wr_own && (!chain_in.wr.vld || (wr_age > chain_in.wr.age))) begin
      chain_nxt.wr.vld  = 1'b1;
      chain_nxt.wr.slot = cell_idx;
      chain_nxt.wr.age  = wr_age;
    end
    if (rd_own && rd_old && (!chain_in.old_rd.vld || (rd_age > chain_in.old_rd.age))) begin
      chain_nxt.old_rd.vld  = 1'b1;
      chain_nxt.old_rd.slot = cell_idx;
      chain_nxt.old_rd.age  = rd_age;
    end
    if (rd_own && !rd_old && (!chain_in.yng_rd.vld || (rd_age > chain_in.yng_rd.age))) begin
      chain_nxt.yng_rd.vld  = 1'b1;
      chain_nxt.yng_rd.slot = cell_idx;
      chain_nxt.yng_rd.age  = rd_age;
    end
  end

  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
  end

  assign chain_out = chain_r;
  assign rd_valid  = rd_vld_r;
  assign wr_valid  = wr_vld_r;

endmodule

`default_nettype wire

[hw/rtl/dram_request_scheduler_write_drain_unit.sv]
// One-channel DRAM request scheduler with watermark write drain and
// oldest-first selection, built as a chain of slot cells and an APB register
// file. Insert, remove and set-ready are taken while idle and each returns a
// result beat. A schedule sweeps the search chain one slot per cycle through
// the registered cell stages; no new command is accepted until its result is
// loaded into the output register, which waits while the result port stalls.
`default_nettype none

`include "assert_macros.svh"

module dram_request_scheduler_write_drain_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // slot[5:0], cycle[37:6], zero pad
  input  wire logic [4:0]  in_tuser,   // command[2:0], is_write_table[3], ready_req[4]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // issued_slot[5:0], zero pad
  output logic [2:0]       out_tuser,  // issued[0], issued_write[1], drain_mode[2]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  localparam int DEPTH = drsw_pkg::QUEUE_DEPTH;

  drsw_pkg::cfg_t                 cfg;
  drsw_pkg::upd_t                 upd;
  drsw_pkg::chain_t               chain_in_s  [DEPTH];
  drsw_pkg::chain_t               chain_out_s [DEPTH];
  drsw_pkg::chain_t               tail;

  logic [DEPTH-1:0]               rd_vld_vec;
  logic [DEPTH-1:0]               wr_vld_vec;

  logic                           state_r;
  logic                           state_nxt;
  logic [drsw_pkg::CNT_W-1:0]     sweep_cnt_r;
  logic [drsw_pkg::CNT_W-1:0]     sweep_cnt_nxt;
  logic [drsw_pkg::CNT_W-1:0]     rd_cnt_r;
  logic [drsw_pkg::CNT_W-1:0]     rd_cnt_nxt;
  logic [drsw_pkg::CNT_W-1:0]     wr_cnt_r;
  logic [drsw_pkg::CNT_W-1:0]     wr_cnt_nxt;
  logic                           drain_r;
  logic                           drain_nxt;
  logic [drsw_pkg::TIME_W-1:0]    now_r;

  logic                           out_vld_r;
  logic                           out_vld_nxt;
  logic                           out_iss_r;
  logic                           out_issw_r;
  logic [5:0]                     out_slot_r;
  logic                           out_drain_r;
  logic                           res_iss;
  logic                           res_issw;
  logic [drsw_pkg::SLOT_W-1:0]    res_slot;

  logic [2:0]                     cmd;
  logic                           wsel;
  logic [5:0]                     slot_in;
  logic [31:0]                    cycle_in;
  logic                           rdy_in;
  logic                           accept;
  logic                           in_range;
  logic [drsw_pkg::SLOT_W-1:0]    slot_idx;
  logic                           is_sched;
  logic                           sweep_done;
  logic                           out_room;
  logic                           load_imm;
  logic [drsw_pkg::CMP_W-1:0]     wc_ext;

  assign cmd      = in_tuser[2:0];
  assign wsel     = in_tuser[3];
  assign rdy_in   = in_tuser[4];
  assign slot_in  = in_tdata[5:0];
  assign cycle_in = in_tdata[37:6];

  assign out_room   = !out_vld_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && out_room;
  assign accept     = in_tvalid && in_tready;
  assign in_range   = (32'(slot_in) < 32'(DEPTH));
  assign slot_idx   = drsw_pkg::SLOT_W'(slot_in);
  assign is_sched   = (cmd == drsw_pkg::CMD_SCHEDULE);
  assign load_imm   = accept && !is_sched;
  assign sweep_done = (state_r == ST_SWEEP) &&
                      (sweep_cnt_r == drsw_pkg::CNT_W'(DEPTH)) && out_room;
  assign tail       = chain_out_s[DEPTH-1];
  assign wc_ext     = drsw_pkg::CMP_W'(wr_cnt_r);

  drsw_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  always_comb begin
    upd         = '0;
    upd.slot    = slot_idx;
    upd.arrival = drsw_pkg::TIME_W'(cycle_in);
    upd.rdy     = rdy_in;
    if (accept && in_range) begin
      case (cmd)
        drsw_pkg::CMD_INS_RD:  upd.ins_rd = 1'b1;
        drsw_pkg::CMD_INS_WR:  upd.ins_wr = 1'b1;
        drsw_pkg::CMD_REMOVE: begin
          upd.rm_rd = !wsel;
          upd.rm_wr = wsel;
        end
        drsw_pkg::CMD_SET_RDY: begin
          upd.set_rd = !wsel;
          upd.set_wr = wsel;
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign chain_in_s[g] = '0;
    end else begin : g_link
      assign chain_in_s[g] = chain_out_s[g-1];
    end
    drsw_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (drsw_pkg::SLOT_W'(g)),
      .upd       (upd),
      .now       (now_r),
      .age_thr   (cfg.age_thr),
      .chain_in  (chain_in_s[g]),
      .chain_out (chain_out_s[g]),
      .rd_valid  (rd_vld_vec[g]),
      .wr_valid  (wr_vld_vec[g])
    );
  end

  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    wr_cnt_nxt = wr_cnt_r;
    if (upd.ins_rd && !rd_vld_vec[slot_idx]) rd_cnt_nxt = rd_cnt_r + drsw_pkg::CNT_W'(1);
    if (upd.rm_rd && rd_vld_vec[slot_idx])   rd_cnt_nxt = rd_cnt_r - drsw_pkg::CNT_W'(1);
    if (upd.ins_wr && !wr_vld_vec[slot_idx]) wr_cnt_nxt = wr_cnt_r + drsw_pkg::CNT_W'(1);
    if (upd.rm_wr && wr_vld_vec[slot_idx])   wr_cnt_nxt = wr_cnt_r - drsw_pkg::CNT_W'(1);
  end

  always_comb begin
    drain_nxt = drain_r;
    if (accept && is_sched) begin
      drain_nxt = (drain_r && (wc_ext > drsw_pkg::CMP_W'(cfg.low_wm))) ||
                  (wc_ext > drsw_pkg::CMP_W'(cfg.high_wm)) ||
                  (rd_cnt_r == '0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_sched) begin
          state_nxt     = ST_SWEEP;
          sweep_cnt_nxt = '0;
        end
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          state_nxt = ST_IDLE;
        end else if (sweep_cnt_r != drsw_pkg::CNT_W'(DEPTH)) begin
          sweep_cnt_nxt = sweep_cnt_r + drsw_pkg::CNT_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_iss  = 1'b0;
    res_issw = 1'b0;
    res_slot = '0;
    if (drain_r) begin
      if (tail.wr.vld) begin
        res_iss  = 1'b1;
        res_issw = 1'b1;
        res_slot = tail.wr.slot;
      end
    end else if (tail.old_rd.vld) begin
      res_iss  = 1'b1;
      res_slot = tail.old_rd.slot;
    end else if (tail.yng_rd.vld) begin
      res_iss  = 1'b1;
      res_slot = tail.yng_rd.slot;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_tready) out_vld_nxt = 1'b0;
    if (load_imm || sweep_done)  out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sweep_cnt_r <= '0;
      rd_cnt_r    <= '0;
      wr_cnt_r    <= '0;
      drain_r     <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      wr_cnt_r    <= wr_cnt_nxt;
      drain_r     <= drain_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_sched) now_r <= drsw_pkg::TIME_W'(cycle_in);
    if (load_imm) begin
      out_iss_r   <= 1'b0;
      out_issw_r  <= 1'b0;
      out_slot_r  <= 6'd0;
      out_drain_r <= drain_r;
    end else if (sweep_done) begin
      out_iss_r   <= res_iss;
      out_issw_r  <= res_issw;
      out_slot_r  <= 6'(res_slot);
      out_drain_r <= drain_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'd0, out_slot_r};
  assign out_tuser  = {out_drain_r, out_issw_r, out_iss_r};

  `DRSW_ASSERT(a_rd_cnt_match, rd_cnt_r == $countones(rd_vld_vec), "read count off valid bits")
  `DRSW_ASSERT(a_wr_cnt_match, wr_cnt_r == $countones(wr_vld_vec), "write count off valid bits")
  `DRSW_ASSERT_IMPL(a_now_hold, (state_r == ST_SWEEP) && $past(state_r == ST_SWEEP),
                    $stable(now_r), "schedule time changed during sweep")
  `DRSW_ASSERT_IMPL(a_issw_drain, out_vld_r && out_issw_r, out_iss_r && out_drain_r,
                    "write issued outside drain mode")

endmodule

`default_nettype wire

[verif/dram_request_scheduler_write_drain_unit_test.sv]
// Self-checking test of the DRAM write drain scheduler: directed cases, register access
// and random command traffic, each result checked against an in-bench scheduler model.
// Depends on drsw_pkg and dram_request_scheduler_write_drain_unit.
module dram_request_scheduler_write_drain_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         SETTLE_CYCLES  = drsw_pkg::QUEUE_DEPTH + 6;
  localparam int         CHUNK_ITEMS    = 215;
  localparam logic [2:0] CMD_LAST       = 3'd7;

  typedef enum {PICK_ANY, PICK_OLD, PICK_YOUNG} pick_mode_t;

  typedef struct packed {
    logic [2:0]                  command;
    logic                        wsel;
    logic [drsw_pkg::SLOT_W-1:0] slot;
    logic [drsw_pkg::TIME_W-1:0] cycle;
    logic                        rdy;
  } sched_cmd_t;

  localparam int CMD_BITS = $bits(sched_cmd_t);

  typedef struct packed {
    logic       issued;
    logic       issued_write;
    logic [7:0] slot_data;
    logic       drain;
  } sched_pick_t;

  typedef struct {
    bit                          valid;
    bit                          ready;
    logic [drsw_pkg::TIME_W-1:0] arrival;
  } slot_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // slot[5:0], cycle[37:6], zero pad
  logic [4:0]  in_tuser = '0;    // command[2:0], is_write_table[3], ready_req[4]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // issued_slot[5:0], zero pad
  logic [2:0]  out_tuser;        // issued[0], issued_write[1], drain_mode[2]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  slot_entry_t                 rd_tab [drsw_pkg::QUEUE_DEPTH];
  slot_entry_t                 wr_tab [drsw_pkg::QUEUE_DEPTH];
  int                          rd_count = 0;
  int                          wr_count = 0;
  bit                          drain_on = 1'b0;
  logic [6:0]                  high_wm = drsw_pkg::HIGH_WM_RST;
  logic [6:0]                  low_wm = drsw_pkg::LOW_WM_RST;
  logic [15:0]                 age_thr = drsw_pkg::AGE_THR_RST;
  bit                          last_issue_valid = 1'b0;
  bit                          last_issue_write = 1'b0;
  logic [drsw_pkg::SLOT_W-1:0] last_issue_slot = '0;
  logic [drsw_pkg::TIME_W-1:0] now_cyc = '0;

  sched_pick_t pending_picks [$];
  int          mismatches = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          quiet_cycles = 0;

  dram_request_scheduler_write_drain_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int oldest_ready(bit from_writes, logic [drsw_pkg::TIME_W-1:0] now,
                                      pick_mode_t mode);
    int                          best;
    logic [drsw_pkg::TIME_W-1:0] best_age;
    logic [drsw_pkg::TIME_W-1:0] age;
    slot_entry_t                 e;
    best = -1;
    best_age = '0;
    for (int i = 0; i < drsw_pkg::QUEUE_DEPTH; i++) begin
      e = from_writes ? wr_tab[i] : rd_tab[i];
      if (!e.valid || !e.ready) continue;
      age = now - e.arrival;
      if (mode == PICK_OLD && age < age_thr) continue;
      if (mode == PICK_YOUNG && age >= age_thr) continue;
      if (best < 0 || age > best_age) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic sched_pick_t predict_pick(sched_cmd_t c);
    sched_pick_t r;
    slot_entry_t e;
    bit          to_wr;
    int          delta;
    int          s;
    r = '0;
    delta = 0;
    to_wr = (c.command == drsw_pkg::CMD_INS_WR) ||
            ((c.command == drsw_pkg::CMD_REMOVE || c.command == drsw_pkg::CMD_SET_RDY) &&
             c.wsel);
    e = to_wr ? wr_tab[c.slot] : rd_tab[c.slot];
    case (c.command)
      drsw_pkg::CMD_INS_RD, drsw_pkg::CMD_INS_WR: begin
        delta = e.valid ? 0 : 1;
        e.valid = 1'b1;
        e.ready = c.rdy;
        e.arrival = c.cycle;
      end
      drsw_pkg::CMD_REMOVE: begin
        delta = e.valid ? -1 : 0;
        e.valid = 1'b0;
        e.ready = 1'b0;
      end
      drsw_pkg::CMD_SET_RDY: begin
        if (e.valid) e.ready = c.rdy;
      end
      drsw_pkg::CMD_SCHEDULE: begin
        drain_on = drain_on && (wr_count > low_wm);
        if (wr_count > high_wm || rd_count == 0) drain_on = 1'b1;
        if (drain_on) begin
          s = oldest_ready(1'b1, c.cycle, PICK_ANY);
        end else begin
          s = oldest_ready(1'b0, c.cycle, PICK_OLD);
          if (s < 0) s = oldest_ready(1'b0, c.cycle, PICK_YOUNG);
        end
        if (s >= 0) begin
          r.issued = 1'b1;
          r.issued_write = drain_on;
          r.slot_data = 8'(s);
          last_issue_valid = 1'b1;
          last_issue_write = drain_on;
          last_issue_slot = drsw_pkg::SLOT_W'(s);
        end
      end
      default: ;
    endcase
    if (c.command < drsw_pkg::CMD_SCHEDULE) begin
      if (to_wr) begin
        wr_tab[c.slot] = e;
        wr_count += delta;
      end else begin
        rd_tab[c.slot] = e;
        rd_count += delta;
      end
    end
    r.drain = drain_on;
    return r;
  endfunction

  function automatic logic [drsw_pkg::SLOT_W-1:0] find_slot(bit from_writes, bit want_valid);
    int          start;
    int          idx;
    slot_entry_t e;
    start = $urandom_range(drsw_pkg::QUEUE_DEPTH - 1);
    for (int i = 0; i < drsw_pkg::QUEUE_DEPTH; i++) begin
      idx = (start + i) % drsw_pkg::QUEUE_DEPTH;
      e = from_writes ? wr_tab[idx] : rd_tab[idx];
      if (e.valid == want_valid) return drsw_pkg::SLOT_W'(idx);
    end
    return drsw_pkg::SLOT_W'(start);
  endfunction

  function automatic sched_cmd_t make_cmd(logic [2:0] command, logic wsel,
                                          logic [drsw_pkg::SLOT_W-1:0] slot,
                                          logic [drsw_pkg::TIME_W-1:0] cycle, logic rdy);
    sched_cmd_t c;
    c.command = command;
    c.wsel = wsel;
    c.slot = slot;
    c.cycle = cycle;
    c.rdy = rdy;
    return c;
  endfunction

  function automatic sched_cmd_t random_command(int w_ins_wr, int w_remove);
    sched_cmd_t c;
    int         roll;
    int         span;
    roll = $urandom_range(99);
    if (roll < 22) c.command = drsw_pkg::CMD_SCHEDULE;
    else if (roll < 25) c.command = 3'($urandom_range(CMD_LAST, drsw_pkg::CMD_SCHEDULE + 1));
    else if (roll < 45) c.command = drsw_pkg::CMD_INS_RD;
    else if (roll < 45 + w_ins_wr) c.command = drsw_pkg::CMD_INS_WR;
    else if (roll < 45 + w_ins_wr + w_remove) c.command = drsw_pkg::CMD_REMOVE;
    else c.command = drsw_pkg::CMD_SET_RDY;
    c.wsel = 1'($urandom_range(1));
    c.rdy = ($urandom_range(99) < 70);
    c.slot = drsw_pkg::SLOT_W'($urandom_range(drsw_pkg::QUEUE_DEPTH - 1));
    c.cycle = now_cyc;
    span = (age_thr == 0) ? 64 : 2 * age_thr + 2;
    case (c.command)
      drsw_pkg::CMD_INS_RD, drsw_pkg::CMD_INS_WR: begin
        if ($urandom_range(99) < 60)
          c.slot = find_slot(c.command == drsw_pkg::CMD_INS_WR, 1'b0);
        c.cycle = now_cyc - drsw_pkg::TIME_W'($urandom_range(span));
      end
      drsw_pkg::CMD_REMOVE, drsw_pkg::CMD_SET_RDY: begin
        if (c.command == drsw_pkg::CMD_REMOVE && last_issue_valid &&
            $urandom_range(99) < 50) begin
          c.wsel = last_issue_write;
          c.slot = last_issue_slot;
        end else if ($urandom_range(99) < 85) begin
          c.slot = find_slot(c.wsel, 1'b1);
        end
      end
      default: ;
    endcase
    if ($urandom_range(99) < 6) c = sched_cmd_t'(CMD_BITS'({$urandom, $urandom}));
    return c;
  endfunction

  task automatic send_item(sched_cmd_t c);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, c.cycle, c.slot};
    in_tuser <= {c.rdy, c.wsel, c.command};
    do @(posedge clk); while (!in_tready);
    pending_picks.push_back(predict_pick(c));
  endtask

  task automatic settle_pipeline();
    in_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    logic [31:0] readback;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      drsw_pkg::REG_HIGH_WM: begin
        high_wm = value[6:0];
        readback = {25'd0, high_wm};
      end
      drsw_pkg::REG_LOW_WM: begin
        low_wm = value[6:0];
        readback = {25'd0, low_wm};
      end
      default: begin
        age_thr = value[15:0];
        readback = {16'd0, age_thr};
      end
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== readback) begin
      if (mismatches < 10)
        $display("register %0d readback: expected %h, got %h", idx, readback, cfg_prdata);
      mismatches++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [31:0] high, logic [31:0] low, logic [31:0] thr);
    write_register(drsw_pkg::REG_HIGH_WM, high);
    write_register(drsw_pkg::REG_LOW_WM, low);
    write_register(drsw_pkg::REG_AGE_THR, thr);
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_item(make_cmd(drsw_pkg::CMD_SCHEDULE, 1'b0, 6'd0, 32'd0, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_INS_RD, 1'b0, 6'd0, 32'd100, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_INS_RD, 1'b0, 6'd63, 32'd100, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_INS_RD, 1'b1, 6'd5, 32'd0, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_SCHEDULE, 1'b1, 6'd63, 32'd120, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_SET_RDY, 1'b0, 6'd5, 32'hFFFF_FFFF, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_SCHEDULE, 1'b0, 6'd0, 32'd150, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_INS_WR, 1'b0, 6'd7, 32'hFFFF_FFF0, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_INS_WR, 1'b0, 6'd8, 32'd0, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_SCHEDULE, 1'b0, 6'd0, 32'd16, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_REMOVE, 1'b0, 6'd0, 32'd0, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_REMOVE, 1'b0, 6'd5, 32'd0, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_REMOVE, 1'b0, 6'd63, 32'd0, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_REMOVE, 1'b0, 6'd0, 32'd0, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_SET_RDY, 1'b1, 6'd30, 32'd0, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_SCHEDULE, 1'b0, 6'd0, 32'd16, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_INS_WR, 1'b1, 6'd7, 32'd10, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_SCHEDULE, 1'b0, 6'd0, 32'd16, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_SET_RDY, 1'b1, 6'd8, 32'd0, 1'b0));
    send_item(make_cmd(drsw_pkg::CMD_SCHEDULE, 1'b0, 6'd0, 32'd16, 1'b0));
    for (int op = drsw_pkg::CMD_SCHEDULE + 1; op <= CMD_LAST; op++)
      send_item(make_cmd(3'(op), 1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_INS_RD, 1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1));
    send_item(make_cmd(drsw_pkg::CMD_SCHEDULE, 1'b0, 6'd0, 32'hFFFF_FFFF, 1'b0));
  endtask

  task automatic test_register_access();
    settle_pipeline();
    configure(32'd0, 32'd0, 32'd0);
    configure(32'd64, 32'd64, 32'd65535);
    configure(drsw_pkg::HIGH_WM_RST, drsw_pkg::LOW_WM_RST, drsw_pkg::AGE_THR_RST);
  endtask

  task automatic test_random_traffic();
    int w_ins_wr;
    int w_remove;
    for (int k = 0; k < 8; k++) begin
      settle_pipeline();
      case (k)
        0: configure(drsw_pkg::HIGH_WM_RST, drsw_pkg::LOW_WM_RST, drsw_pkg::AGE_THR_RST);
        1: configure(32'd0, 32'd0, 32'd0);
        2: configure(32'd64, 32'd64, 32'd65535);
        3: configure(32'd64, 32'd0, 32'd1);
        4: configure(32'd10, 32'd30, 32'd200);
        5: configure(32'd20, 32'd10, $urandom_range(400));
        6: configure($urandom_range(64), $urandom_range(64), $urandom_range(65535));
        default: configure(32'd32, 32'd16, $urandom_range(1000));
      endcase
      case (k % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 72;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 72;
        end
        default: begin
          sender_idle_pct = 23;
          receiver_stall_pct = 23;
        end
      endcase
      w_ins_wr = $urandom_range(30, 10);
      w_remove = $urandom_range(25, 8);
      now_cyc = ($urandom_range(3) == 0) ? 32'hFFFF_F000 : $urandom;
      repeat (CHUNK_ITEMS) begin
        send_item(random_command(w_ins_wr, w_remove));
        now_cyc = now_cyc + drsw_pkg::TIME_W'($urandom_range(8));
      end
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    sched_pick_t seen;
    sched_pick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.issued = out_tuser[0];
      seen.issued_write = out_tuser[1];
      seen.slot_data = out_tdata;
      seen.drain = out_tuser[2];
      if (pending_picks.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: issued=%0d write=%0d slot=%0d drain=%0d",
                   seen.issued, seen.issued_write, seen.slot_data, seen.drain);
        mismatches++;
      end else begin
        want = pending_picks.pop_front();
        if (seen !== want) begin
          if (mismatches < 10)
            $display("pick mismatch: expected issued=%0d write=%0d slot=%0d drain=%0d",
                     want.issued, want.issued_write, want.slot_data, want.drain,
                     ", got issued=%0d write=%0d slot=%0d drain=%0d",
                     seen.issued, seen.issued_write, seen.slot_data, seen.drain);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_register_access();
    test_random_traffic();
    settle_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
